FILE: rtl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  localparam int POOL_SLOTS      = 64;
  localparam int MAX_BLOCK_BYTES = 4096;

  // field widths
  localparam int IN_OFS_W = 21;
  localparam int OFS_W    = 18;
  localparam int CNT_W    = 7;
  localparam int BYTES_W  = 13;
  localparam int IDX_W    = $clog2(POOL_SLOTS);
  localparam int LIMIT_W  = CNT_W + BYTES_W;

  // bitmap memory: rows of ROW_W flags
  localparam int ROW_W     = 8;
  localparam int ROWS      = POOL_SLOTS / ROW_W;
  localparam int ROW_IDX_W = $clog2(ROWS);
  localparam int BIT_IDX_W = $clog2(ROW_W);

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = BYTES_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BYTES = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [BYTES_W-1:0] BYTES_RST = BYTES_W'(64);
  localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(64);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_RANGE,
    S_DIV,
    S_FREE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/fbpa_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle, MSB first.
// The caller guarantees dividend < 2**IDX_W * divisor.
module fbpa_div (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire  [fbpa_pkg::OFS_W-1:0]      dividend,
  input  wire  [fbpa_pkg::BYTES_W-1:0]    divisor,
  output logic                            done,
  output logic [fbpa_pkg::IDX_W-1:0]      quotient
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(IDX_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [OFS_W-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0]    quo_r, quo_nxt;
  logic [OFS_W-1:0]    shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    shifted  = OFS_W'(divisor) << step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(IDX_W - 1);
      rem_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (rem_r >= shifted) begin
        rem_nxt = rem_r - shifted;
        quo_nxt = {quo_r[IDX_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[IDX_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");

endmodule

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator.sv
// channel   direction  handshake          word
// in_       input      in_valid/in_stall  in_op, in_byte_offset
// out_      output     out_valid/out_stall out_status, out_block_offset, out_used_count
// cfg_      input      cfg_we             cfg_addr, cfg_wdata
//
// One request at a time. Allocate: time grows with the rows scanned (8 rows of
// 8 flags), set by the one-row-per-cycle bitmap memory read. Free inside the pool:
// time set by the serial divider (one quotient bit per cycle) and the read-modify-write.
// Reset clears per-row valid flags at once, so the bitmap reads as all free; no sweep.
// A finished word waits in the output register while the next request is taken.
`default_nettype none

module fixed_block_pool_allocator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_op,
  input  wire  signed [fbpa_pkg::IN_OFS_W-1:0] in_byte_offset,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_status,
  output logic [fbpa_pkg::OFS_W-1:0]          out_block_offset,
  output logic [fbpa_pkg::CNT_W-1:0]          out_used_count,
  input  wire                                 cfg_we,
  input  wire  [fbpa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbpa_pkg::*;

  state_t                 state_r, state_nxt;
  logic [BYTES_W-1:0]     block_bytes_r;
  logic [CNT_W-1:0]       block_count_r;
  logic [BYTES_W-1:0]     eff_bytes;
  logic [CNT_W-1:0]       eff_count;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic [IN_OFS_W-2:0]    ofs_r, ofs_nxt;
  logic [LIMIT_W-1:0]     limit_r, limit_nxt;
  logic [ROW_IDX_W-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [OFS_W-1:0]       res_offset_r, res_offset_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [OFS_W-1:0]       out_offset_r, out_offset_nxt;
  logic [CNT_W-1:0]       out_used_r, out_used_nxt;

  // bitmap memory
  logic [ROW_W-1:0]       mem [ROWS];
  logic [ROWS-1:0]        row_vld_r;
  logic [ROW_W-1:0]       rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_en, wr_en;
  logic [ROW_IDX_W-1:0]   rd_addr, wr_addr;
  logic [ROW_W-1:0]       wr_data;
  logic [ROW_W-1:0]       cur_row;

  logic                   div_start, div_done;
  logic [IDX_W-1:0]       div_quo;

  logic                   accept;
  logic [ROW_IDX_W-1:0]   last_row;
  logic                   scan_found;
  logic [BIT_IDX_W-1:0]   scan_bit;
  logic [ROW_W-1:0]       busy_bits;

  always_comb begin
    if (block_bytes_r == '0) begin
      eff_bytes = BYTES_W'(1);
    end else if (block_bytes_r > BYTES_W'(MAX_BLOCK_BYTES)) begin
      eff_bytes = BYTES_W'(MAX_BLOCK_BYTES);
    end else begin
      eff_bytes = block_bytes_r;
    end
    if (block_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (block_count_r > CNT_W'(POOL_SLOTS)) begin
      eff_count = CNT_W'(POOL_SLOTS);
    end else begin
      eff_count = block_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BYTES_RST;
      block_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BLOCK_BYTES: block_bytes_r <= cfg_wdata;
        CFG_BLOCK_COUNT: block_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ofs_r[OFS_W-1:0]),
    .divisor  (eff_bytes),
    .done     (div_done),
    .quotient (div_quo)
  );

  // a row never written reads as all free
  assign cur_row  = rd_vld_r ? rd_data_r : '0;
  assign last_row = ROW_IDX_W'((eff_count - 1'b1) >> BIT_IDX_W);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // blocks at or past the effective block count count as taken
  always_comb begin
    scan_found = 1'b0;
    scan_bit   = '0;
    for (int b = 0; b < ROW_W; b++) begin
      busy_bits[b] = cur_row[b] ||
                     ({1'b0, row_r, BIT_IDX_W'(b)} >= eff_count);
    end
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!busy_bits[b]) begin
        scan_found = 1'b1;
        scan_bit   = BIT_IDX_W'(b);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    ofs_nxt        = ofs_r;
    limit_nxt      = limit_r;
    row_nxt        = row_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_offset_nxt = res_offset_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_used_nxt   = out_used_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = row_r;
    wr_data        = cur_row;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_offset_nxt = '0;
          if (in_op == OP_ALLOC) begin
            if (used_r >= eff_count) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              row_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_SCAN;
            end
          end else if (in_byte_offset[IN_OFS_W-1]) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_DONE;
          end else begin
            ofs_nxt   = in_byte_offset[IN_OFS_W-2:0];
            limit_nxt = LIMIT_W'(eff_count) * LIMIT_W'(eff_bytes);
            state_nxt = S_RANGE;
          end
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          wr_en     = 1'b1;
          wr_addr   = row_r;
          wr_data   = cur_row | (ROW_W'(1) << scan_bit);
          idx_nxt   = {row_r, scan_bit};
          used_nxt  = used_r + 1'b1;
          state_nxt = S_MUL;
        end else if (row_r == last_row) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          row_nxt = row_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = row_r + 1'b1;
        end
      end
      S_MUL: begin
        res_offset_nxt = OFS_W'(LIMIT_W'(idx_r) * LIMIT_W'(eff_bytes));
        res_status_nxt = ST_ALLOCATED;
        state_nxt      = S_DONE;
      end
      S_RANGE: begin
        if (LIMIT_W'(ofs_r) >= limit_r) begin
          res_status_nxt = ST_IGNORED;
          state_nxt      = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_nxt   = div_quo;
          rd_en     = 1'b1;
          rd_addr   = div_quo[IDX_W-1:BIT_IDX_W];
          state_nxt = S_FREE;
        end
      end
      S_FREE: begin
        if (cur_row[idx_r[BIT_IDX_W-1:0]]) begin
          wr_en          = 1'b1;
          wr_addr        = idx_r[IDX_W-1:BIT_IDX_W];
          wr_data        = cur_row & ~(ROW_W'(1) << idx_r[BIT_IDX_W-1:0]);
          used_nxt       = (used_r != '0) ? used_r - 1'b1 : used_r;
          res_status_nxt = ST_RELEASED;
        end else begin
          res_status_nxt = ST_IGNORED;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_offset_nxt = res_offset_r;
          out_used_nxt   = used_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ofs_r        <= ofs_nxt;
    limit_r      <= limit_nxt;
    row_r        <= row_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_used_r   <= out_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_offset_r;
  assign out_used_count   = out_used_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(POOL_SLOTS)) else $error("used count beyond pool");
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SCAN || state_r == S_FREE))
    else $error("bitmap written outside scan or free");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE) else $error("request accepted but not started");
  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_found) |=> used_r == $past(used_r) + 1'b1)
    else $error("allocation did not bump used count");
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_ALLOCATED) |-> out_offset_r == '0)
    else $error("nonzero offset on non-allocation word");

endmodule

`default_nettype wire
